// File: rtl/whole_word_occurrence_counter_assert.svh
// assertion macros for the whole-word occurrence counter
`ifndef WHOLE_WORD_OCCURRENCE_COUNTER_ASSERT_SVH
`define WHOLE_WORD_OCCURRENCE_COUNTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WWOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WWOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wwoc_pkg.sv
package wwoc_pkg;

  localparam int unsigned OUT_BITS   = 24;
  localparam int unsigned LEN_BITS   = 5;
  localparam int unsigned CFG_BITS   = 64;
  localparam int unsigned WORD_SLOTS = 16;

  // request opcodes
  localparam logic [1:0] OP_TEXT  = 2'd0;
  localparam logic [1:0] OP_EOM   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_WORD_LO  = 2'd0;
  localparam logic [1:0] CFG_WORD_HI  = 2'd1;
  localparam logic [1:0] CFG_WORD_LEN = 2'd2;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic push;
    logic eom;
    logic clr;
  } win_ctl_t;

  function automatic logic is_delim(logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_COMMA) || (c == CH_SPACE) || (c == CH_LF) ||
           (c == CH_TAB) || (c == CH_DOT) || (c == CH_NUL);
  endfunction

endpackage

// File: rtl/wwoc_window.sv
module wwoc_window #(
  parameter int unsigned MAX_WORD = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wwoc_pkg::win_ctl_t                 ctl_i,
  input  logic [7:0]                         byte_i,
  output logic [MAX_WORD-1:0][7:0]           recent_o,
  output logic [MAX_WORD-1:0]                marks_o,
  output logic [$clog2(MAX_WORD+1)-1:0]      held_o
);

  localparam int unsigned CW = $clog2(MAX_WORD + 1);

  logic [MAX_WORD-1:0][7:0] recent_q, recent_d;
  logic [MAX_WORD-1:0]      marks_q, marks_d;
  logic [CW-1:0]            held_q, held_d;
  logic                     bound_q, bound_d;

  always_comb begin
    recent_d = recent_q;
    marks_d  = marks_q;
    held_d   = held_q;
    bound_d  = bound_q;
    if (ctl_i.clr) begin
      recent_d = '0;
      marks_d  = '0;
      held_d   = '0;
      bound_d  = 1'b1;
    end else if (ctl_i.eom) begin
      held_d  = '0;
      bound_d = 1'b1;
    end else if (ctl_i.push) begin
      // index 0 holds the newest byte
      for (int i = 1; i < MAX_WORD; i++) begin
        recent_d[i] = recent_q[i-1];
        marks_d[i]  = marks_q[i-1];
      end
      recent_d[0] = byte_i;
      marks_d[0]  = bound_q;
      if (held_q < CW'(MAX_WORD)) held_d = held_q + 1'b1;
      bound_d = wwoc_pkg::is_delim(byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      marks_q  <= '0;
      held_q   <= '0;
      bound_q  <= 1'b1;
    end else begin
      recent_q <= recent_d;
      marks_q  <= marks_d;
      held_q   <= held_d;
      bound_q  <= bound_d;
    end
  end

  assign recent_o = recent_q;
  assign marks_o  = marks_q;
  assign held_o   = held_q;

endmodule

// File: rtl/wwoc_match.sv
module wwoc_match #(
  parameter int unsigned MAX_WORD = 16
) (
  input  logic [wwoc_pkg::CFG_BITS-1:0]      word_lo_i,
  input  logic [wwoc_pkg::CFG_BITS-1:0]      word_hi_i,
  input  logic [wwoc_pkg::LEN_BITS-1:0]      word_len_i,
  input  logic [MAX_WORD-1:0][7:0]           recent_i,
  input  logic [MAX_WORD-1:0]                marks_i,
  input  logic [$clog2(MAX_WORD+1)-1:0]      held_i,
  input  logic                               check_i,
  output logic                               hit_o
);

  localparam int unsigned IW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  logic [wwoc_pkg::WORD_SLOTS-1:0][7:0] word;
  logic [7:0]                           len;
  logic [7:0]                           len_m1;
  logic [7:0]                           held;
  logic [MAX_WORD-1:0]                  eq;
  logic                                 start_ok;

  assign word = {word_hi_i, word_lo_i};
  assign held = 8'(held_i);

  always_comb begin
    // lengths above the window size are clamped to it
    len = 8'(word_len_i);
    if (len > 8'(MAX_WORD)) len = 8'(MAX_WORD);
    len_m1 = len - 8'd1;
  end

  assign start_ok = marks_i[len_m1[IW-1:0]];

  // window slot i lines up with word byte len-1-i; bytes past the sixteenth are zero
  always_comb begin
    logic [7:0] j;
    logic [7:0] wb;
    for (int i = 0; i < MAX_WORD; i++) begin
      j  = len_m1 - 8'(i);
      wb = (j < 8'(wwoc_pkg::WORD_SLOTS)) ? word[j[3:0]] : 8'h00;
      eq[i] = (8'(i) >= len) || (recent_i[i] == wb);
    end
  end

  assign hit_o = check_i && (len != 8'd0) && (held >= len) && start_ok && (&eq);

endmodule

// File: rtl/whole_word_occurrence_counter.sv
// channel   direction  payload                        handshake
// request   in         op_i, text_byte_i              in_valid_i / in_stall_o
// result    out        occurrences_o, matched_now_o   out_valid_o / out_stall_i
// config    in         cfg_index_i, cfg_data_i        cfg_we_i
//
// one request per cycle sustained while the result is not stalled; the result register loads from the input register
// (input register at acceptance, then window compare and count into the result register)
// the window compare is one parallel byte compare across all word positions
// reset clears window, count and handshake state; word registers reset to zero, length to 1
// a stalled result still lets one request into the input register
`include "whole_word_occurrence_counter_assert.svh"

module whole_word_occurrence_counter #(
  parameter int unsigned MAX_WORD   = 16,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic [7:0]                        text_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wwoc_pkg::OUT_BITS-1:0]     occurrences_o,
  output logic                              matched_now_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [wwoc_pkg::CFG_BITS-1:0]     cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_WORD + 1);
  localparam int unsigned EXT_W = wwoc_pkg::OUT_BITS + COUNT_BITS;

  logic [wwoc_pkg::CFG_BITS-1:0] word_lo_q, word_hi_q;
  logic [wwoc_pkg::LEN_BITS-1:0] word_len_q;

  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_op_q;
  logic [7:0] s1_byte_q;

  logic                  out_valid_q, out_valid_d;
  logic                  flag_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  cnt_sat;
  logic [EXT_W-1:0]      cnt_ext;

  logic                     in_acc;
  logic                     out_free;
  logic                     adv;
  logic                     check;
  logic                     hit;
  wwoc_pkg::win_ctl_t       ctl;
  logic [MAX_WORD-1:0][7:0] recent;
  logic [MAX_WORD-1:0]      marks;
  logic [CW-1:0]            held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_lo_q  <= '0;
      word_hi_q  <= '0;
      word_len_q <= wwoc_pkg::LEN_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wwoc_pkg::CFG_WORD_LO:  word_lo_q  <= cfg_data_i;
        wwoc_pkg::CFG_WORD_HI:  word_hi_q  <= cfg_data_i;
        wwoc_pkg::CFG_WORD_LEN: word_len_q <= cfg_data_i[wwoc_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc)   s1_valid_d = 1'b1;
    else if (adv) s1_valid_d = 1'b0;
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= op_i;
      s1_byte_q <= text_byte_i;
    end
    if (adv) flag_q <= hit;
  end

  always_comb begin
    ctl.push = adv && (s1_op_q == wwoc_pkg::OP_TEXT);
    ctl.eom  = adv && (s1_op_q == wwoc_pkg::OP_EOM);
    ctl.clr  = adv && (s1_op_q == wwoc_pkg::OP_CLEAR);
    check    = ((s1_op_q == wwoc_pkg::OP_TEXT) && wwoc_pkg::is_delim(s1_byte_q)) ||
               (s1_op_q == wwoc_pkg::OP_EOM);
  end

  wwoc_window #(
    .MAX_WORD (MAX_WORD)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .byte_i   (s1_byte_q),
    .recent_o (recent),
    .marks_o  (marks),
    .held_o   (held)
  );

  wwoc_match #(
    .MAX_WORD (MAX_WORD)
  ) u_match (
    .word_lo_i  (word_lo_q),
    .word_hi_i  (word_hi_q),
    .word_len_i (word_len_q),
    .recent_i   (recent),
    .marks_i    (marks),
    .held_i     (held),
    .check_i    (check),
    .hit_o      (hit)
  );

  // saturating match count
  assign cnt_sat = &cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (ctl.clr)                    cnt_d = '0;
    else if (adv && hit && !cnt_sat) cnt_d = cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // count only moves on advance, so it holds steady while the result waits
  assign cnt_ext       = EXT_W'(cnt_q);
  assign occurrences_o = cnt_ext[wwoc_pkg::OUT_BITS-1:0];
  assign matched_now_o = flag_q;
  assign out_valid_o   = out_valid_q;

  `WWOC_ASSERT_NOW(a_stall_needs_item, in_stall_o, s1_valid_q, "stall with empty input register")
  `WWOC_ASSERT_NOW(a_flag_has_count, out_valid_o && matched_now_o, cnt_q != '0, "match with zero count")
  `WWOC_ASSERT_NEXT(a_clear_zeroes, ctl.clr, cnt_q == '0, "count not cleared")
  `WWOC_ASSERT_NEXT(a_hit_counts, adv && hit && !cnt_sat && !ctl.clr, cnt_q == $past(cnt_q) + 1'b1, "count did not step on match")

endmodule
